// ===== rtl/tpbd_pkg.sv =====
package tpbd_pkg;

	localparam int PULSE_W    = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_CODE   = 2'd1;

	localparam logic [1:0] TAP_VERSION_RESET = 2'd1;
	localparam logic [8:0] V0_ZERO_PULSE     = 9'd256;

	typedef enum logic [2:0] {
		EV_DATA   = 3'd0,
		EV_END    = 3'd1,
		EV_BADBIT = 3'd2,
		EV_PARITY = 3'd3,
		EV_LEAD   = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		CLS_OTHER  = 2'd0,
		CLS_SHORT  = 2'd1,
		CLS_MIDDLE = 2'd2,
		CLS_LONG   = 2'd3
	} pulse_class_t;

	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [7:0]  data;
	} tpbd_result_t;

	function automatic pulse_class_t classify(input logic [PULSE_W-1:0] p);
		pulse_class_t c;
		if (p >= 21'd36 && p <= 21'd54) begin
			c = CLS_SHORT;
		end else if (p >= 21'd55 && p <= 21'd73) begin
			c = CLS_MIDDLE;
		end else if (p >= 21'd74 && p <= 21'd100) begin
			c = CLS_LONG;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

endpackage

// ===== rtl/tpbd_frame.sv =====
module tpbd_frame (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [tpbd_pkg::PULSE_W-1:0]      pulse,
	input  logic                              turbo,
	input  logic                              clear,
	output tpbd_pkg::tpbd_result_t            result
);

	typedef enum logic [1:0] {
		PH_WAIT_LEAD,
		PH_WAIT_MARK,
		PH_BITS
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [3:0]              bit_count_q, bit_count_d;
	logic                    pair_half_q, pair_half_d;
	tpbd_pkg::pulse_class_t  first_class_q, first_class_d;
	logic [7:0]              shift_q, shift_d;
	logic                    parity_q, parity_d;

	tpbd_pkg::pulse_class_t  cls;
	logic                    bit_val;
	logic                    bit_ok;
	logic [3:0]              count_inc;
	logic [7:0]              turbo_shift;

	always_comb begin
		cls         = tpbd_pkg::classify(pulse);
		count_inc   = bit_count_q + 4'd1;
		bit_val     = 1'b0;
		bit_ok      = 1'b1;
		turbo_shift = 8'd0;

		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		pair_half_d   = pair_half_q;
		first_class_d = first_class_q;
		shift_d       = shift_q;
		parity_d      = parity_q;

		result.valid = 1'b0;
		result.kind  = tpbd_pkg::EV_DATA;
		result.data  = 8'd0;

		if (turbo) begin
			if (pulse >= 21'd35 && pulse <= 21'd54) begin
				bit_val = 1'b1;
			end else if (pulse >= 21'd10 && pulse <= 21'd34) begin
				bit_val = 1'b0;
			end else begin
				bit_ok = 1'b0;
			end
			turbo_shift = {shift_q[6:0], bit_val};
			if (!bit_ok) begin
				result.valid = 1'b1;
				result.kind  = tpbd_pkg::EV_BADBIT;
			end else if (count_inc >= 4'd8) begin
				result.valid = 1'b1;
				result.kind  = tpbd_pkg::EV_DATA;
				result.data  = turbo_shift;
			end else begin
				shift_d     = turbo_shift;
				bit_count_d = count_inc;
			end
		end else begin
			case (phase_q)
				PH_WAIT_LEAD: begin
					if (cls == tpbd_pkg::CLS_LONG) begin
						phase_d = PH_WAIT_MARK;
					end else begin
						result.valid = 1'b1;
						result.kind  = tpbd_pkg::EV_LEAD;
					end
				end
				PH_WAIT_MARK: begin
					if (cls == tpbd_pkg::CLS_SHORT) begin
						result.valid = 1'b1;
						result.kind  = tpbd_pkg::EV_END;
					end else if (cls == tpbd_pkg::CLS_LONG) begin
						result.valid = 1'b1;
						result.kind  = tpbd_pkg::EV_BADBIT;
					end
				end
				PH_BITS: begin
					if (!pair_half_q) begin
						first_class_d = cls;
						pair_half_d   = 1'b1;
					end else begin
						pair_half_d = 1'b0;
						if (first_class_q == tpbd_pkg::CLS_SHORT &&
						    (cls == tpbd_pkg::CLS_MIDDLE || cls == tpbd_pkg::CLS_LONG)) begin
							bit_val = 1'b0;
						end else if ((first_class_q == tpbd_pkg::CLS_MIDDLE ||
						              first_class_q == tpbd_pkg::CLS_LONG) &&
						             cls == tpbd_pkg::CLS_SHORT) begin
							bit_val = 1'b1;
						end else begin
							bit_ok = 1'b0;
						end
						if (!bit_ok) begin
							result.valid = 1'b1;
							result.kind  = tpbd_pkg::EV_BADBIT;
						end else if (bit_count_q < 4'd8) begin
							shift_d     = {bit_val, shift_q[7:1]};
							parity_d    = parity_q ^ bit_val;
							bit_count_d = count_inc;
						end else begin
							result.valid = 1'b1;
							if (bit_val == parity_q) begin
								result.kind = tpbd_pkg::EV_DATA;
								result.data = shift_q;
							end else begin
								result.kind = tpbd_pkg::EV_PARITY;
							end
						end
					end
				end
				default: begin
					phase_d = PH_WAIT_LEAD;
				end
			endcase
		end

		// Every reported event ends the current frame. A good start mark also
		// starts a fresh frame, now in the bit-pair phase.
		if (result.valid || (!turbo && phase_q == PH_WAIT_MARK)) begin
			phase_d       = (!result.valid) ? PH_BITS : PH_WAIT_LEAD;
			bit_count_d   = 4'd0;
			pair_half_d   = 1'b0;
			first_class_d = tpbd_pkg::CLS_OTHER;
			shift_d       = 8'd0;
			parity_d      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT_LEAD;
			bit_count_q   <= 4'd0;
			pair_half_q   <= 1'b0;
			first_class_q <= tpbd_pkg::CLS_OTHER;
			shift_q       <= 8'd0;
			parity_q      <= 1'b1;
		end else if (clear) begin
			phase_q       <= PH_WAIT_LEAD;
			bit_count_q   <= 4'd0;
			pair_half_q   <= 1'b0;
			first_class_q <= tpbd_pkg::CLS_OTHER;
			shift_q       <= 8'd0;
			parity_q      <= 1'b1;
		end else if (en) begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			pair_half_q   <= pair_half_d;
			first_class_q <= first_class_d;
			shift_q       <= shift_d;
			parity_q      <= parity_d;
		end
	end

	// A frame never holds more than eight collected bits.
	assert property (@(posedge clk) disable iff (!arst_n) bit_count_q <= 4'd8)
		else $error("tpbd_frame: bit count beyond eight");

	// The second pulse of a pair is only expected while decoding bit pairs.
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_half_q |-> (phase_q == PH_BITS && !clear && !turbo) || turbo || clear)
		else $error("tpbd_frame: pair half set outside the bit phase");

endmodule

// ===== rtl/tape_pulse_byte_decoder_top.sv =====
// A TAP byte transfer is registered in the input stage, and its event, if any, is loaded into
// the output register when that stage advances (output register empty or out_ready high).
// Throughput: one TAP byte per cycle unless the output stalls (one frame logic pass).
// Long-length bytes of a zero prefix give no output; the event comes with the last one.
// Reset (arst_n low, asynchronous): both stages empty, tap_version 1, line_code 0,
// framing back to waiting for a lead pulse.
module tape_pulse_byte_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         tap_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         event_kind,
	output logic [7:0]                         data_byte,
	input  logic                               cfg_we,
	input  logic [tpbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                              valid_s1;
	logic [7:0]                        byte_s1;
	logic [1:0]                        tap_version_q;
	logic                              line_code_q;
	logic [1:0]                        ext_count_q;
	logic [15:0]                       ext_value_q;
	logic                              out_valid_q;
	logic [2:0]                        kind_q;
	logic [7:0]                        data_q;

	logic                              advance;
	logic                              pulse_go;
	logic [tpbd_pkg::PULSE_W-1:0]      pulse;
	logic                              frame_clear;
	tpbd_pkg::tpbd_result_t            res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign frame_clear = cfg_we && cfg_index == tpbd_pkg::REG_LINE_CODE;

	always_comb begin
		pulse    = {13'd0, byte_s1};
		pulse_go = 1'b0;
		if (ext_count_q != 2'd0) begin
			// The last length byte is the top byte; the length is divided by eight.
			pulse    = {byte_s1, ext_value_q[15:3]};
			pulse_go = (ext_count_q == 2'd1);
		end else if (byte_s1 == 8'd0) begin
			pulse    = {12'd0, tpbd_pkg::V0_ZERO_PULSE};
			pulse_go = (tap_version_q == 2'd0);
		end else begin
			pulse_go = 1'b1;
		end
	end

	tpbd_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && pulse_go),
		.pulse  (pulse),
		.turbo  (line_code_q),
		.clear  (frame_clear),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= tap_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_version_q <= tpbd_pkg::TAP_VERSION_RESET;
			line_code_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpbd_pkg::REG_TAP_VERSION: tap_version_q <= cfg_data;
				tpbd_pkg::REG_LINE_CODE:   line_code_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_count_q <= 2'd0;
			ext_value_q <= 16'd0;
		end else if (advance) begin
			if (ext_count_q == 2'd3) begin
				ext_value_q[7:0] <= byte_s1;
				ext_count_q      <= 2'd2;
			end else if (ext_count_q == 2'd2) begin
				ext_value_q[15:8] <= byte_s1;
				ext_count_q       <= 2'd1;
			end else if (ext_count_q == 2'd1) begin
				ext_value_q <= 16'd0;
				ext_count_q <= 2'd0;
			end else if (byte_s1 == 8'd0 && tap_version_q != 2'd0) begin
				ext_value_q <= 16'd0;
				ext_count_q <= 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pulse_go && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pulse_go && res.valid) begin
			kind_q <= res.kind;
			data_q <= res.data;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign data_byte  = data_q;

	// Each length byte moves the gathering count down by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && ext_count_q == 2'd3 |=> ext_count_q == 2'd2)
		else $error("tpbd: length byte count did not step");

	// No pulse reaches the frame logic while a long length is half gathered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ext_count_q == 2'd3 || ext_count_q == 2'd2) |-> !pulse_go)
		else $error("tpbd: pulse decoded from a partial length");

	// Only data events carry a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != tpbd_pkg::EV_DATA |-> data_q == 8'd0)
		else $error("tpbd: non-data event with a nonzero byte");

	// An empty input stage always takes the next transfer.
	assert property (@(posedge clk) disable iff (!arst_n) !valid_s1 |-> in_ready)
		else $error("tpbd: empty input stage refused a transfer");

endmodule
